// File: src/tftq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftq_pkg
// Shared types and constants for the task fifo and timer queue.
// ----------------------------------------------------------------------------
package tftq_pkg;
   localparam int TASK_DEPTH  = 16;
   localparam int TIMER_DEPTH = 16;
   localparam int ID_BITS     = 32;
   localparam int TASK_AW     = $clog2(TASK_DEPTH) > 0 ? $clog2(TASK_DEPTH) : 1;
   localparam int TIMER_AW    = $clog2(TIMER_DEPTH) > 0 ? $clog2(TIMER_DEPTH) : 1;
   localparam int TIMER_CW    = $clog2(TIMER_DEPTH + 1);
   localparam int TASK_CW     = $clog2(TASK_DEPTH + 1);
   localparam logic [63:0] NS_PER_MS = 64'd1000000;
   // largest delay allowed for a given now is floor((2^64-1-now)/1e6)

   typedef enum logic [1:0] {
      OP_POST = 2'd0, OP_ARM = 2'd1, OP_CANCEL = 2'd2, OP_RUN = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_DISABLED = 3'd1, ST_OVERFLOW = 3'd2, ST_FULL = 3'd3,
      ST_CLOCK = 3'd4, ST_BAD_ID = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      RK_NONE = 2'd0, RK_TASK = 2'd1, RK_TIMER = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] task_tag;
      logic [63:0] wait_ms;
      logic [63:0] now_ns;
      logic [31:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  ran_kind;
      logic [31:0] fired_tag;
      logic [31:0] new_timer_id;
      logic        cancel_found;
      logic [63:0] tasks_run_count;
      logic [63:0] timers_run_count;
   } rsp_type;

   // timer entry held in memory
   localparam int ENTRY_W = 64 + ID_BITS + 32;
   typedef struct packed {
      logic [63:0]        due;
      logic [ID_BITS-1:0] ident;
      logic [31:0]        handle;
   } entry_type;

   // scan request and result between control and scanner
   typedef struct packed {
      logic               start;
      logic               match_id;
      logic [ID_BITS-1:0] id;
   } scan_cmd_type;

   typedef struct packed {
      logic                done;
      logic                found;
      logic [TIMER_AW-1:0] slot;
      entry_type           entry;
   } scan_res_type;
endpackage

// File: src/tftq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftq_req_if / tftq_rsp_if / tftq_csr_if
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------
interface tftq_req_if import tftq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tftq_rsp_if import tftq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tftq_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/tftq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftq_ram
// Generic single-port-write, single-port-read ram with registered read.
// ----------------------------------------------------------------------------
module tftq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: src/tftq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftq_scan
// Walks the timer memory one slot a cycle, finding the earliest valid entry
// (optionally restricted to one id), ties to smaller id then lower slot.
// ----------------------------------------------------------------------------
module tftq_scan import tftq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  scan_cmd_type           cmd,
   input  logic [TIMER_DEPTH-1:0] valid_bits,
   output logic [TIMER_AW-1:0]    rd_addr,
   input  entry_type              rd_data,
   output scan_res_type           res
);
   logic                busy_ff, busy_in;
   logic                pend_ff, pend_in;   // read data of slot pslot_ff arrives now
   logic [TIMER_AW-1:0] pslot_ff, pslot_in;
   logic [TIMER_CW-1:0] idx_ff, idx_in;
   logic                match_ff, match_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic                found_ff, found_in;
   logic [TIMER_AW-1:0] bslot_ff, bslot_in;
   entry_type           best_ff, best_in;
   logic                done_ff, done_in;
   logic                take;

   assign rd_addr = idx_ff[TIMER_AW-1:0];

   always_comb begin
      take = pend_ff && valid_bits[pslot_ff] && (!match_ff || rd_data.ident == id_ff) &&
             (!found_ff || rd_data.due < best_ff.due ||
              (rd_data.due == best_ff.due && rd_data.ident < best_ff.ident));
      busy_in  = busy_ff;
      pend_in  = 1'b0;
      pslot_in = pslot_ff;
      idx_in   = idx_ff;
      match_in = match_ff;
      id_in    = id_ff;
      found_in = found_ff || take;
      bslot_in = take ? pslot_ff : bslot_ff;
      best_in  = take ? rd_data : best_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         match_in = cmd.match_id;
         id_in    = cmd.id;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (idx_ff == TIMER_CW'(TIMER_DEPTH)) begin
            // last slot is compared this cycle, so the best is final next cycle
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            pend_in  = 1'b1;
            pslot_in = idx_ff[TIMER_AW-1:0];
            idx_in   = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      pslot_ff <= pslot_in;
      idx_ff   <= idx_in;
      match_ff <= match_in;
      id_ff    <= id_in;
      bslot_ff <= bslot_in;
      best_ff  <= best_in;
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.slot  = bslot_ff;
   assign res.entry = best_ff;
endmodule

// File: src/task_fifo_and_timer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_fifo_and_timer_queue_top
// Event scheduler: task fifo plus timer store, one response per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every request first builds the due
// time and the overflow flag in S_MULT (two 32 by 20 bit products) and then
// S_SUM (one wide add), and is decided in S_CHECK. Post, arm and every refused
// or rejected request then go straight to S_RESP; a run that pops a queued
// task passes through S_FIFO first. Cancel, and a run that reaches the timers,
// read every timer slot through the timer memory's single read port, one slot
// a cycle, in S_SCAN and S_WAIT. The response moves into an output register,
// so the next request is taken while the last word waits; only when that
// register is still full does the block stall before answering. No clearing
// pass is needed after reset.
module task_fifo_and_timer_queue_top import tftq_pkg::*; (
   input logic      clock,
   input logic      reset,
   tftq_req_if.sink   req,
   tftq_rsp_if.source rsp,
   tftq_csr_if.sink   csr
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_MULT  = 8'b00000010,
      S_SUM   = 8'b00000100,
      S_CHECK = 8'b00001000,
      S_SCAN  = 8'b00010000,
      S_WAIT  = 8'b00100000,
      S_FIFO  = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   rsp_type              out_ff;
   logic                 out_valid_ff;
   logic                 out_load;
   logic                 en_ff;
   logic [TASK_AW-1:0]   head_ff, head_in;
   logic [TASK_CW-1:0]   count_ff, count_in;
   logic [TIMER_DEPTH-1:0] valid_ff, valid_in;
   logic [ID_BITS-1:0]   next_id_ff, next_id_in;
   logic [63:0]          tasks_ff, tasks_in, timers_ff, timers_in;
   logic [51:0]          plo_ff, phi_ff;
   logic [85:0]          wide_sum;
   logic                 ovf_ff;
   logic [63:0]          due_ff;

   logic                 tw_en;
   logic [TASK_AW-1:0]   tw_addr, tr_addr;
   logic [31:0]          tr_data;
   logic                 ew_en;
   logic [TIMER_AW-1:0]  ew_addr, er_addr;
   entry_type            ew_data, er_data;
   scan_cmd_type         scmd;
   scan_res_type         sres;
   logic                 free_any;
   logic [TIMER_AW-1:0]  free_slot;
   logic [ID_BITS-1:0]   id_a, id_b;

   // now + delay * 1e6 at full width; any bit above 63 means overflow
   assign wide_sum = {2'b00, phi_ff, 32'd0} + {34'd0, plo_ff} + {22'd0, req_ff.now_ns};

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
   assign csr.ready = 1'b1;
   assign out_load  = (state_ff == S_RESP) && (!out_valid_ff || rsp.ready);

   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = TIMER_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = TIMER_AW'(i);
         end
      end
      id_a = next_id_ff;
      id_b = next_id_ff + 1'b1;
   end

   tftq_ram #(.WIDTH(32), .DEPTH(TASK_DEPTH)) u_task_ram (
      .clock, .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(req_ff.task_tag),
      .rd_addr(tr_addr), .rd_data(tr_data));

   tftq_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_DEPTH)) u_timer_ram (
      .clock, .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(er_addr), .rd_data(er_data));

   tftq_scan u_scan (
      .clock, .reset, .cmd(scmd), .valid_bits(valid_ff),
      .rd_addr(er_addr), .rd_data(er_data), .res(sres));

   assign tr_addr = head_ff;

   always_comb begin
      logic [TASK_AW+1:0] wsum;
      wsum      = {2'b00, head_ff} + (TASK_AW + 2)'(count_ff);
      state_in  = state_ff;
      rsp_in    = rsp_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      next_id_in = next_id_ff;
      tasks_in  = tasks_ff;
      timers_in = timers_ff;
      tw_en     = 1'b0;
      tw_addr   = TASK_AW'(wsum % TASK_DEPTH);
      ew_en     = 1'b0;
      ew_addr   = free_slot;
      ew_data.due    = due_ff;
      ew_data.ident  = (id_a == '0) ? id_b : id_a;
      ew_data.handle = req_ff.task_tag;
      scmd.start    = 1'b0;
      scmd.match_id = (req_ff.op == OP_CANCEL);
      scmd.id       = ID_BITS'(req_ff.cancel_id);
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            rsp_in = '0;
            case (op_type'(req_ff.op))
               OP_POST: begin
                  if (count_ff == TASK_CW'(TASK_DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     tw_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_RESP;
               end
               OP_ARM: begin
                  state_in = S_RESP;
                  if (!en_ff) rsp_in.status = ST_DISABLED;
                  else if (req_ff.now_ns == '0) rsp_in.status = ST_CLOCK;
                  else if (ovf_ff) rsp_in.status = ST_OVERFLOW;
                  else if (!free_any) rsp_in.status = ST_FULL;
                  else begin
                     ew_en = 1'b1;
                     valid_in[free_slot] = 1'b1;
                     rsp_in.new_timer_id = 32'(ew_data.ident);
                     next_id_in = (id_a == '0) ? id_b + 1'b1 : id_b;
                  end
               end
               OP_CANCEL: begin
                  if (req_ff.cancel_id == '0) begin
                     rsp_in.status = ST_BAD_ID;
                     state_in = S_RESP;
                  end else begin
                     scmd.start = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (count_ff != '0) begin
                     state_in = S_FIFO;
                  end else if (req_ff.now_ns == '0) begin
                     rsp_in.status = ST_CLOCK;
                     state_in = S_RESP;
                  end else begin
                     scmd.start = 1'b1;
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_SCAN: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sres.done) begin
               state_in = S_RESP;
               if (req_ff.op == OP_CANCEL) begin
                  if (sres.found) begin
                     valid_in[sres.slot] = 1'b0;
                     rsp_in.cancel_found = 1'b1;
                  end
               end else if (sres.found && sres.entry.due <= req_ff.now_ns) begin
                  valid_in[sres.slot] = 1'b0;
                  rsp_in.ran_kind  = RK_TIMER;
                  rsp_in.fired_tag = sres.entry.handle;
                  tasks_in  = tasks_ff + 1'b1;
                  timers_in = timers_ff + 1'b1;
               end
            end
         end
         S_FIFO: begin
            rsp_in.ran_kind  = RK_TASK;
            rsp_in.fired_tag = tr_data;
            head_in  = TASK_AW'(({1'b0, head_ff} + 1'b1) % TASK_DEPTH);
            count_in = count_ff - 1'b1;
            tasks_in = tasks_ff + 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_RESP) begin
         rsp_in.tasks_run_count  = tasks_in;
         rsp_in.timers_run_count = timers_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= 1'b1;
         head_ff      <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         next_id_ff   <= ID_BITS'(1);
         tasks_ff     <= '0;
         timers_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr.valid) en_ff <= csr.data;
         head_ff    <= head_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
         next_id_ff <= next_id_in;
         tasks_ff   <= tasks_in;
         timers_ff  <= timers_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      rsp_ff <= rsp_in;
      if (out_load) out_ff <= rsp_ff;
      if (req.valid && req.ready) begin
         req_ff <= req.data;
      end
      if (state_ff == S_MULT) begin
         plo_ff <= 52'(req_ff.wait_ms[31:0]) * 52'(NS_PER_MS[19:0]);
         phi_ff <= 52'(req_ff.wait_ms[63:32]) * 52'(NS_PER_MS[19:0]);
      end
      if (state_ff == S_SUM) begin
         due_ff <= wide_sum[63:0];
         ovf_ff <= |wide_sum[85:64];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(out_ff))
      else $error("response changed while held");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= TASK_CW'(TASK_DEPTH))
      else $error("task count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && req_ff.op == OP_ARM && rsp_in.new_timer_id != '0)
      |=> next_id_ff != '0 || $past(next_id_ff) == '1)
      else $error("id counter handed out zero");
endmodule
